FILE: rtl/core/centered_moving_average_unit_defines.svh
// Assertion macros shared by the checker of the centered moving average unit
`ifndef CENTERED_MOVING_AVERAGE_UNIT_DEFINES_SVH
`define CENTERED_MOVING_AVERAGE_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off while reset is asserted
`define CMA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on i_clk, off while reset is asserted
`define CMA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/cma_pkg.sv
// Shared constants, ALU op codes and control struct for the moving average unit
`timescale 1ns / 1ps

package cma_pkg;

    // Defaults for top-level parameters
    localparam int CMA_MAX_HALF_WIDTH = 31;
    localparam int CMA_SAMPLE_BITS    = 24;

    // Fixed widths
    localparam int CMA_HW_BITS    = 5;   // half width register and output
    localparam int CMA_PTR_BITS   = 6;   // 64-entry sample ring
    localparam int CMA_CNT_BITS   = 7;   // saturating sample count
    localparam int CMA_SUM_GROWTH = 6;   // up to 63 terms in a window sum
    localparam int CMA_DIV_BITS   = 6;   // divisor 2w+1, at most 63
    localparam int CMA_REM_BITS   = 7;   // partial remainder, below 2 * divisor

    // Shared ALU operations
    typedef logic [2:0] t_alu_op;
    localparam t_alu_op ALU_NOP = 3'd0;
    localparam t_alu_op ALU_CLR = 3'd1;  // clear sum, load divisor
    localparam t_alu_op ALU_ACC = 3'd2;  // add one ring sample
    localparam t_alu_op ALU_ABS = 3'd3;  // take magnitude, keep sign
    localparam t_alu_op ALU_DIV = 3'd4;  // one restoring division step
    localparam t_alu_op ALU_SGN = 3'd5;  // restore sign of quotient

    typedef struct packed {
        t_alu_op                 op;
        logic [CMA_DIV_BITS-1:0] divisor;
    } t_alu_ctrl;

endpackage

FILE: rtl/core/centered_moving_average_unit.sv
// Per result: 2w+1 ring reads on the single read port, w = half window used, then
//   magnitude, one quotient bit per cycle of a restoring divide, and sign fixup.
// The input is ready only in idle, so a new sample is not taken until all results it
//   causes have been loaded; one output register decouples the result side.
// Reset: synchronous, active low; clears counters, pointers, half width and valid flags.
// Ring contents are not cleared; only slots written in the current series are read.
`timescale 1ns / 1ps

module centered_moving_average_unit import cma_pkg::*; #(
    parameter int MAX_HALF_WIDTH = CMA_MAX_HALF_WIDTH,
    parameter int SAMPLE_BITS    = CMA_SAMPLE_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CMA_HW_BITS-1:0] i_cfg_half_width,
    // sample input
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  logic                   i_final_req,
    // result output
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [SAMPLE_BITS-1:0] o_smoothed,
    output logic [CMA_HW_BITS-1:0] o_used_half_width,
    output logic                   o_run_end
);

    localparam int SUM_BITS  = SAMPLE_BITS + CMA_SUM_GROWTH;
    localparam int DCNT_BITS = $clog2(SUM_BITS + 1);
    localparam logic [CMA_HW_BITS-1:0] MAX_H = CMA_HW_BITS'(MAX_HALF_WIDTH);

    // Sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_SUM   = 3'd2;
    localparam logic [2:0] S_ABS   = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_SGN   = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0]              r_state;
    logic [CMA_HW_BITS-1:0]  r_half_width;
    logic [CMA_CNT_BITS-1:0] r_seen;
    logic [CMA_PTR_BITS-1:0] r_wp;
    logic [CMA_PTR_BITS-1:0] r_emit;
    logic                    r_fin;
    logic [CMA_HW_BITS-1:0]  r_w;
    logic                    r_last;
    logic [CMA_PTR_BITS-1:0] r_rd_addr;
    logic [CMA_PTR_BITS-1:0] r_rd_left;
    logic                    r_rd_vld;
    logic [DCNT_BITS-1:0]    r_div_cnt;
    logic                    r_out_valid;
    logic [SAMPLE_BITS-1:0]  r_out_smoothed;
    logic [CMA_HW_BITS-1:0]  r_out_hw;
    logic                    r_out_end;

    logic                    w_in_xfer;
    logic                    w_out_load;
    logic [CMA_HW_BITS-1:0]  w_h;
    logic [CMA_PTR_BITS-1:0] w_pending;
    logic                    w_do_emit;
    logic [CMA_PTR_BITS-1:0] w_back;
    logic [CMA_CNT_BITS-1:0] w_p_index;
    logic [CMA_HW_BITS-1:0]  w_w1;
    logic [CMA_HW_BITS-1:0]  w_w;
    logic                    w_rd_en;
    logic [SAMPLE_BITS-1:0]  w_rd_data;
    logic [SAMPLE_BITS-1:0]  w_result;
    t_alu_ctrl               w_ctrl;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign w_in_xfer   = i_in_valid && o_in_ready;
    assign w_out_load  = (r_state == S_OUT) && (!r_out_valid || i_out_ready);
    assign w_rd_en     = (r_state == S_SUM) && (r_rd_left != '0);

    // Effective half width and window of the oldest pending point
    always_comb begin
        w_h       = (r_half_width > MAX_H) ? MAX_H : r_half_width;
        w_pending = r_wp - r_emit;
        w_do_emit = r_fin ? (w_pending != '0) : (w_pending > {1'b0, w_h});
        w_back    = r_wp - CMA_PTR_BITS'(1) - r_emit;
        w_p_index = (r_seen > {1'b0, w_back})
                  ? (r_seen - CMA_CNT_BITS'(1) - {1'b0, w_back}) : '0;
        w_w1      = (w_p_index < {2'b0, w_h}) ? w_p_index[CMA_HW_BITS-1:0] : w_h;
        w_w       = (w_back < {1'b0, w_w1}) ? w_back[CMA_HW_BITS-1:0] : w_w1;
    end

    // ALU control
    always_comb begin
        w_ctrl.op      = ALU_NOP;
        w_ctrl.divisor = {w_w, 1'b1};
        unique case (r_state)
            S_CHECK: w_ctrl.op = w_do_emit ? ALU_CLR : ALU_NOP;
            S_SUM:   w_ctrl.op = r_rd_vld ? ALU_ACC : ALU_NOP;
            S_ABS:   w_ctrl.op = ALU_ABS;
            S_DIV:   w_ctrl.op = ALU_DIV;
            S_SGN:   w_ctrl.op = ALU_SGN;
            default: w_ctrl.op = ALU_NOP;
        endcase
    end

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_width <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_half_width <= i_cfg_half_width;
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_seen    <= '0;
            r_wp      <= '0;
            r_emit    <= '0;
            r_fin     <= 1'b0;
            r_rd_left <= '0;
            r_rd_vld  <= 1'b0;
            r_div_cnt <= '0;
        end else begin
            r_rd_vld <= w_rd_en;
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_xfer) begin
                        r_wp  <= r_wp + CMA_PTR_BITS'(1);
                        r_fin <= i_final_req;
                        if (r_seen != '1) begin
                            r_seen <= r_seen + CMA_CNT_BITS'(1);
                        end
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (w_do_emit) begin
                        r_w       <= w_w;
                        r_last    <= r_fin && (w_pending == CMA_PTR_BITS'(1));
                        r_rd_addr <= r_emit - {1'b0, w_w};
                        r_rd_left <= {w_w, 1'b1};
                        r_state   <= S_SUM;
                    end else begin
                        if (r_fin) begin
                            r_seen <= '0;
                            r_wp   <= '0;
                            r_emit <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                S_SUM: begin
                    if (w_rd_en) begin
                        r_rd_addr <= r_rd_addr + CMA_PTR_BITS'(1);
                        r_rd_left <= r_rd_left - CMA_PTR_BITS'(1);
                    end else if (!r_rd_vld) begin
                        r_state <= S_ABS;
                    end
                end
                S_ABS: begin
                    r_div_cnt <= DCNT_BITS'(SUM_BITS);
                    r_state   <= S_DIV;
                end
                S_DIV: begin
                    r_div_cnt <= r_div_cnt - DCNT_BITS'(1);
                    if (r_div_cnt == DCNT_BITS'(1)) begin
                        r_state <= S_SGN;
                    end
                end
                S_SGN: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (w_out_load) begin
                        r_emit  <= r_emit + CMA_PTR_BITS'(1);
                        r_state <= S_CHECK;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_smoothed <= w_result;
            r_out_hw       <= r_w;
            r_out_end      <= r_last;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_smoothed        = r_out_smoothed;
    assign o_used_half_width = r_out_hw;
    assign o_run_end         = r_out_end;

    cma_ring #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (w_in_xfer),
        .i_wr_addr (r_wp),
        .i_wr_data (i_sample),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (r_rd_addr),
        .o_rd_data (w_rd_data)
    );

    cma_alu #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_alu (
        .i_clk     (i_clk),
        .i_ctrl    (w_ctrl),
        .i_rd_data (w_rd_data),
        .o_result  (w_result)
    );

endmodule

FILE: rtl/core/cma_ring.sv
// 64-entry sample ring: one write port, one read port with registered data
`timescale 1ns / 1ps

module cma_ring import cma_pkg::*; #(
    parameter int SAMPLE_BITS = CMA_SAMPLE_BITS
) (
    input  logic                    i_clk,
    input  logic                    i_wr_en,
    input  logic [CMA_PTR_BITS-1:0] i_wr_addr,
    input  logic [SAMPLE_BITS-1:0]  i_wr_data,
    input  logic                    i_rd_en,
    input  logic [CMA_PTR_BITS-1:0] i_rd_addr,
    output logic [SAMPLE_BITS-1:0]  o_rd_data
);

    localparam int DEPTH = 1 << CMA_PTR_BITS;

    logic [SAMPLE_BITS-1:0] r_mem [DEPTH];
    logic [SAMPLE_BITS-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/core/cma_alu.sv
// Shared add/subtract unit: window sum, magnitude, restoring divide, sign fixup
`timescale 1ns / 1ps

module cma_alu import cma_pkg::*; #(
    parameter int SAMPLE_BITS = CMA_SAMPLE_BITS
) (
    input  logic                   i_clk,
    input  t_alu_ctrl              i_ctrl,
    input  logic [SAMPLE_BITS-1:0] i_rd_data,
    output logic [SAMPLE_BITS-1:0] o_result
);

    localparam int SUM_BITS = SAMPLE_BITS + CMA_SUM_GROWTH;

    logic [SUM_BITS-1:0]     r_acc;   // sum, then dividend/quotient shifter
    logic [CMA_REM_BITS-1:0] r_rem;
    logic [CMA_DIV_BITS-1:0] r_div;
    logic                    r_neg;

    logic [SUM_BITS-1:0]     w_a;
    logic [SUM_BITS-1:0]     w_b;
    logic                    w_sub;
    logic [SUM_BITS-1:0]     w_sum;
    logic [CMA_REM_BITS-1:0] w_partial;
    logic                    w_qbit;

    // Next partial remainder: shift in the top dividend bit
    assign w_partial = {r_rem[CMA_REM_BITS-2:0], r_acc[SUM_BITS-1]};

    // Operand select
    always_comb begin
        w_a   = '0;
        w_b   = '0;
        w_sub = 1'b0;
        unique case (i_ctrl.op)
            ALU_ACC: begin
                w_a = r_acc;
                w_b = {{(SUM_BITS-SAMPLE_BITS){i_rd_data[SAMPLE_BITS-1]}}, i_rd_data};
            end
            ALU_ABS, ALU_SGN: begin
                w_b   = r_acc;
                w_sub = 1'b1;
            end
            ALU_DIV: begin
                w_a   = {{(SUM_BITS-CMA_REM_BITS){1'b0}}, w_partial};
                w_b   = {{(SUM_BITS-CMA_DIV_BITS){1'b0}}, r_div};
                w_sub = 1'b1;
            end
            default: begin
                w_sub = 1'b0;
            end
        endcase
    end

    // The one adder
    assign w_sum  = w_a + (w_sub ? ~w_b : w_b) + SUM_BITS'(w_sub);
    assign w_qbit = ~w_sum[SUM_BITS-1];

    // Register update per operation
    always_ff @(posedge i_clk) begin
        unique case (i_ctrl.op)
            ALU_CLR: begin
                r_acc <= '0;
                r_rem <= '0;
                r_div <= i_ctrl.divisor;
            end
            ALU_ACC: begin
                r_acc <= w_sum;
            end
            ALU_ABS: begin
                r_neg <= r_acc[SUM_BITS-1];
                if (r_acc[SUM_BITS-1]) begin
                    r_acc <= w_sum;
                end
            end
            ALU_DIV: begin
                r_acc <= {r_acc[SUM_BITS-2:0], w_qbit};
                r_rem <= w_qbit ? w_sum[CMA_REM_BITS-1:0] : w_partial;
            end
            ALU_SGN: begin
                if (r_neg) begin
                    r_acc <= w_sum;
                end
            end
            default: begin
                r_acc <= r_acc;
            end
        endcase
    end

    assign o_result = r_acc[SAMPLE_BITS-1:0];

endmodule

FILE: rtl/core/cma_checker.sv
// Port-level assertions for the centered moving average unit, bound to the top level
`timescale 1ns / 1ps
`include "centered_moving_average_unit_defines.svh"

module cma_checker import cma_pkg::*; #(
    parameter int MAX_HALF_WIDTH = CMA_MAX_HALF_WIDTH,
    parameter int SAMPLE_BITS    = CMA_SAMPLE_BITS
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_valid,
    input logic                   o_in_ready,
    input logic                   o_out_valid,
    input logic                   i_out_ready,
    input logic [SAMPLE_BITS-1:0] o_smoothed,
    input logic [CMA_HW_BITS-1:0] o_used_half_width,
    input logic                   o_run_end
);

    // A sample transfer keeps the block busy for at least the next cycle
    `CMA_ASSERT_NEXT(a_busy_after_in, i_in_valid && o_in_ready, !o_in_ready, "input ready right after a sample transfer")

    // A stalled result holds its value
    `CMA_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_smoothed) && $stable(o_used_half_width) && $stable(o_run_end), "stalled result changed")

    // Applied half window never exceeds the build limit
    `CMA_ASSERT_NOW(a_hw_limit, o_out_valid, o_used_half_width <= CMA_HW_BITS'(MAX_HALF_WIDTH), "half window above limit")

    // The last point of a series has no right neighbor, so its window is one sample
    `CMA_ASSERT_NOW(a_end_window, o_out_valid && o_run_end, o_used_half_width == '0, "series end with nonzero half window")

endmodule

bind centered_moving_average_unit cma_checker #(
    .MAX_HALF_WIDTH (MAX_HALF_WIDTH),
    .SAMPLE_BITS    (SAMPLE_BITS)
) u_cma_checker (.*);
